/* hw/rtl/krt_pkg.sv */
// ----------------------------------------------------------------------------
// krt_pkg
// shared widths and codes of the keyed record table
// ----------------------------------------------------------------------------
package krt_pkg;

	localparam int ACTION_W = 2;
	localparam int KEY_W    = 32;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int INDEX_W  = 6;
	localparam int FILL_W   = 7;

	// request actions
	localparam logic [ACTION_W-1:0] ACT_SEARCH = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_UPDATE = 2'd3;

	// response status
	localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_PRESENT = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_MISSING = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd3;

endpackage

/* hw/rtl/krt_req_if.sv */
// ----------------------------------------------------------------------------
// krt_req_if
// request channel of the keyed record table
// ----------------------------------------------------------------------------
interface krt_req_if;

	logic                               valid;
	logic                               ready;
	logic        [krt_pkg::ACTION_W-1:0] action;
	logic signed [krt_pkg::KEY_W-1:0]    key;
	logic signed [krt_pkg::VALUE_W-1:0]  new_value;

	modport source (output valid, action, key, new_value, input ready);
	modport sink   (input valid, action, key, new_value, output ready);

endinterface

/* hw/rtl/krt_rsp_if.sv */
// ----------------------------------------------------------------------------
// krt_rsp_if
// response channel of the keyed record table
// ----------------------------------------------------------------------------
interface krt_rsp_if;

	logic                          valid;
	logic                          ready;
	logic [krt_pkg::STATUS_W-1:0]  status;
	logic [krt_pkg::INDEX_W-1:0]   entry_index;
	logic [krt_pkg::FILL_W-1:0]    fill_count;

	modport source (output valid, status, entry_index, fill_count, input ready);
	modport sink   (input valid, status, entry_index, fill_count, output ready);

endinterface

/* hw/rtl/krt_ram.sv */
// ----------------------------------------------------------------------------
// krt_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module krt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hw/rtl/keyed_record_table.sv */
// ----------------------------------------------------------------------------
// keyed_record_table
// ordered key/value table with search, insert, remove with compaction and
// value update, kept in two single-read-port rams
// ----------------------------------------------------------------------------
// sequence: search, insert and update scan the entries from index 0 until a
//   hit or the end of the table, then act and respond; remove walks on from
//   the hit through the later entries and moves each down by one (nothing
//   moves when the last entry goes)
// throughput: one request at a time, one ram read per cycle for scan and shift
// reset: fill count cleared at once, ram contents left as they are
// ----------------------------------------------------------------------------
module keyed_record_table #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic clk,
	input  logic arst_n,
	krt_req_if.sink   req,
	krt_rsp_if.source rsp
);

	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_ACT   = 3'd2;
	localparam logic [2:0] ST_SHIFT = 3'd3;
	localparam logic [2:0] ST_RESP  = 3'd4;

	logic [2:0]                         state_q;
	logic [CW-1:0]                      count_q;
	logic [CW-1:0]                      ptr_q;
	logic                               pend_s1;
	logic [IW-1:0]                      pidx_s1;
	logic                               hit_q;
	logic [IW-1:0]                      hidx_q;
	logic [krt_pkg::ACTION_W-1:0]       action_q;
	logic [krt_pkg::KEY_W-1:0]          key_q;
	logic [krt_pkg::VALUE_W-1:0]        value_q;
	logic [krt_pkg::STATUS_W-1:0]       res_status_q;
	logic [IW-1:0]                      res_idx_q;
	logic                               out_vld_q;
	logic [krt_pkg::STATUS_W-1:0]       out_status_q;
	logic [krt_pkg::INDEX_W-1:0]        out_idx_q;
	logic [krt_pkg::FILL_W-1:0]         out_fill_q;

	logic                               req_fire;
	logic                               more;
	logic                               issue;
	logic                               match;
	logic                               table_full;
	logic                               out_free;
	logic                               key_we;
	logic                               val_we;
	logic [IW-1:0]                      key_waddr;
	logic [IW-1:0]                      val_waddr;
	logic [krt_pkg::KEY_W-1:0]          key_wdata;
	logic [krt_pkg::VALUE_W-1:0]        val_wdata;
	logic [krt_pkg::KEY_W-1:0]          key_rd;
	logic [krt_pkg::VALUE_W-1:0]        val_rd;
	logic [IW+krt_pkg::INDEX_W-1:0]     idx_ext;
	logic [CW+krt_pkg::FILL_W-1:0]      fill_ext;

	assign req_fire   = req.valid && req.ready;
	assign more       = ptr_q < count_q;
	assign issue      = (state_q == ST_SCAN || state_q == ST_SHIFT) && more;
	assign match      = pend_s1 && (key_rd == key_q);
	assign table_full = count_q == CW'(TABLE_DEPTH);
	assign out_free   = !out_vld_q || rsp.ready;
	assign idx_ext    = {{krt_pkg::INDEX_W{1'b0}}, res_idx_q};
	assign fill_ext   = {{krt_pkg::FILL_W{1'b0}}, count_q};

	assign req.ready       = state_q == ST_IDLE;
	assign rsp.valid       = out_vld_q;
	assign rsp.status      = out_status_q;
	assign rsp.entry_index = out_idx_q;
	assign rsp.fill_count  = out_fill_q;

	// ram write side
	always_comb begin
		key_we    = 1'b0;
		val_we    = 1'b0;
		key_waddr = count_q[IW-1:0];
		val_waddr = count_q[IW-1:0];
		key_wdata = key_q;
		val_wdata = value_q;
		unique case (state_q)
			ST_ACT: begin
				if (action_q == krt_pkg::ACT_INSERT && !hit_q && !table_full) begin
					key_we = 1'b1;
					val_we = 1'b1;
				end else if (action_q == krt_pkg::ACT_UPDATE && hit_q) begin
					val_we    = 1'b1;
					val_waddr = hidx_q;
				end
			end
			ST_SHIFT: begin
				key_we    = pend_s1;
				val_we    = pend_s1;
				key_waddr = pidx_s1 - IW'(1);
				val_waddr = pidx_s1 - IW'(1);
				key_wdata = key_rd;
				val_wdata = val_rd;
			end
			default: begin
			end
		endcase
	end

	krt_ram #(
		.WIDTH(krt_pkg::KEY_W),
		.DEPTH(TABLE_DEPTH)
	) u_key_ram (
		.clk  (clk),
		.we   (key_we),
		.waddr(key_waddr),
		.wdata(key_wdata),
		.re   (issue),
		.raddr(ptr_q[IW-1:0]),
		.rdata(key_rd)
	);

	krt_ram #(
		.WIDTH(krt_pkg::VALUE_W),
		.DEPTH(TABLE_DEPTH)
	) u_val_ram (
		.clk  (clk),
		.we   (val_we),
		.waddr(val_waddr),
		.wdata(val_wdata),
		.re   (issue),
		.raddr(ptr_q[IW-1:0]),
		.rdata(val_rd)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			ptr_q     <= '0;
			pend_s1   <= 1'b0;
			hit_q     <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (rsp.ready && state_q != ST_RESP) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						ptr_q   <= '0;
						pend_s1 <= 1'b0;
						hit_q   <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (match) begin
						hit_q   <= 1'b1;
						pend_s1 <= 1'b0;
						state_q <= ST_ACT;
					end else if (more) begin
						pend_s1 <= 1'b1;
						ptr_q   <= ptr_q + CW'(1);
					end else begin
						pend_s1 <= 1'b0;
						if (!pend_s1) begin
							state_q <= ST_ACT;
						end
					end
				end
				ST_ACT: begin
					state_q <= ST_RESP;
					if (action_q == krt_pkg::ACT_INSERT) begin
						if (!hit_q && !table_full) begin
							count_q <= count_q + CW'(1);
						end
					end else if (hit_q && action_q == krt_pkg::ACT_REMOVE) begin
						ptr_q   <= CW'(hidx_q) + CW'(1);
						state_q <= ST_SHIFT;
					end
				end
				ST_SHIFT: begin
					if (more) begin
						pend_s1 <= 1'b1;
						ptr_q   <= ptr_q + CW'(1);
					end else begin
						pend_s1 <= 1'b0;
						if (!pend_s1) begin
							count_q <= count_q - CW'(1);
							state_q <= ST_RESP;
						end
					end
				end
				ST_RESP: begin
					if (out_free) begin
						out_vld_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (req_fire) begin
			action_q <= req.action;
			key_q    <= req.key;
			value_q  <= req.new_value;
		end
		if (issue) begin
			pidx_s1 <= ptr_q[IW-1:0];
		end
		if (state_q == ST_SCAN && match) begin
			hidx_q <= pidx_s1;
		end
		if (state_q == ST_ACT) begin
			res_status_q <= krt_pkg::STAT_OK;
			res_idx_q    <= '0;
			if (action_q == krt_pkg::ACT_INSERT) begin
				if (hit_q) begin
					res_status_q <= krt_pkg::STAT_PRESENT;
				end else if (table_full) begin
					res_status_q <= krt_pkg::STAT_FULL;
				end else begin
					res_idx_q <= count_q[IW-1:0];
				end
			end else if (!hit_q) begin
				res_status_q <= krt_pkg::STAT_MISSING;
			end else begin
				res_idx_q <= hidx_q;
			end
		end
		if (state_q == ST_RESP && out_free) begin
			out_status_q <= res_status_q;
			out_idx_q    <= idx_ext[krt_pkg::INDEX_W-1:0];
			out_fill_q   <= fill_ext[krt_pkg::FILL_W-1:0];
		end
	end

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("fill count beyond table depth");

	a_no_stale_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_RESP) |-> !pend_s1)
		else $error("read pending outside scan or shift");

	a_count_change: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |->
		($past(state_q) == ST_ACT || $past(state_q) == ST_SHIFT))
		else $error("fill count changed outside an update step");

	a_shift_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT && pend_s1) |-> (pidx_s1 != '0 && pidx_s1 > hidx_q))
		else $error("shift write below removed entry");

endmodule
